// ===== rtl/rtp_pkg.sv =====
// Constants and types shared by the RTP fixed-header parser.
package rtp_pkg;

    localparam int unsigned MAX_LEN = 4096;
    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int OFF_W = 19;
    localparam int HDR_W = 7;
    localparam int OUT_W = 13;

    localparam logic [LEN_W-1:0] MAX_POS   = LEN_W'(MAX_LEN);
    localparam logic [LEN_W-1:0] FIXED_HDR = LEN_W'(12);
    localparam logic [HDR_W-1:0] HDR_BASE  = HDR_W'(12);
    localparam logic [OFF_W-1:0] EXT_HDR   = OFF_W'(4);
    localparam logic [1:0]       RTP_VERSION = 2'd2;

    localparam int BIT_PAD = 5;
    localparam int BIT_EXT = 4;
    localparam int BIT_MARKER = 7;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [7:0]       first_byte;
        logic [7:0]       second_byte;
        logic [15:0]      seq;
        logic [31:0]      stamp;
        logic [31:0]      source;
        logic [HDR_W-1:0] hdr_off;
        logic [OFF_W-1:0] ext_off;
        logic [7:0]       pad_count;
        logic             too_long;
    } rtp_snap_t;

endpackage

// ===== rtl/rtp_header_parser.sv =====
// RTP fixed-header parser: byte stream in, one header summary per packet out.
//
// Input channel (s_): one packet byte per transfer in wire order, s_last on
// the final byte. Result channel (m_): one transfer per packet carrying ok,
// marker, payload type, sequence number, timestamp, SSRC and the payload
// start and length; all fields other than ok are zero when ok is low.
// Every byte is absorbed in the cycle it is accepted, so one byte per cycle
// is sustained while s_ready is high. The final byte is captured into a
// snapshot register, and the checks run between the snapshot and the
// result register.
// Snapshot and result register form a two-deep pipeline: while m_ready is
// low, one more packet's final byte can be taken before s_ready drops;
// non-final bytes stall only when that pipeline is full.
// Reset (aresetn low at a clock edge) clears the packet state and empties
// both pipeline stages. Packets longer than MAX_LEN bytes are reported with
// ok low at their final byte.
module rtp_header_parser
    import rtp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_ok,
    output logic        m_marker,
    output logic [6:0]  m_payload_type,
    output logic [15:0] m_sequence_number,
    output logic [31:0] m_time_stamp,
    output logic [31:0] m_source_id,
    output logic [12:0] m_payload_start,
    output logic [12:0] m_payload_length,
    output logic        m_valid,
    input  logic        m_ready
);

    logic [LEN_W-1:0] pos_reg, pos_next, upd_pos;
    logic [7:0]  first_byte_reg, first_byte_next, upd_first;
    logic [7:0]  second_byte_reg, second_byte_next, upd_second;
    logic [15:0] seq_reg, seq_next, upd_seq;
    logic [31:0] stamp_reg, stamp_next, upd_stamp;
    logic [31:0] source_reg, source_next, upd_source;
    logic [15:0] ext_words_reg, ext_words_next, upd_ext;
    logic        too_long_reg, too_long_next, upd_too_long;

    rtp_snap_t   snap_reg, snap_next;
    logic        snap_valid_reg, snap_valid_next;

    logic        out_valid_reg, out_valid_next;
    logic        ok_reg, ok_next;
    logic        marker_reg, marker_next;
    logic [6:0]  ptype_reg, ptype_next;
    logic [15:0] oseq_reg, oseq_next;
    logic [31:0] ostamp_reg, ostamp_next;
    logic [31:0] osource_reg, osource_next;
    logic [OUT_W-1:0] pstart_reg, pstart_next;
    logic [OUT_W-1:0] plen_reg, plen_next;

    logic             s_xfer, out_load, snap_move, at_max;
    logic [HDR_W-1:0] hdr_end_cur, hdr_off_upd;
    logic [LEN_W-1:0] ext_hi_pos, ext_lo_pos;

    logic [OFF_W-1:0] len_ext, off_sel, avail, pad_ext, pay_len;
    logic             good_base, pad_bad, good;

    assign out_load  = !out_valid_reg || m_ready;
    assign snap_move = snap_valid_reg && out_load;
    assign s_ready   = !snap_valid_reg || out_load;
    assign s_xfer    = s_valid && s_ready;

    // per-byte header capture
    assign at_max      = pos_reg >= MAX_POS;
    assign hdr_end_cur = HDR_BASE + {first_byte_reg[3:0], 2'b00};
    assign ext_hi_pos  = LEN_W'(hdr_end_cur) + LEN_W'(2);
    assign ext_lo_pos  = LEN_W'(hdr_end_cur) + LEN_W'(3);

    always_comb begin
        upd_pos      = pos_reg;
        upd_first    = first_byte_reg;
        upd_second   = second_byte_reg;
        upd_seq      = seq_reg;
        upd_stamp    = stamp_reg;
        upd_source   = source_reg;
        upd_ext      = ext_words_reg;
        upd_too_long = too_long_reg;
        if (at_max) begin
            upd_too_long = 1'b1;
        end else begin
            if (pos_reg == LEN_W'(0)) begin
                upd_first = s_data_byte;
            end else if (pos_reg == LEN_W'(1)) begin
                upd_second = s_data_byte;
            end else if (pos_reg < LEN_W'(4)) begin
                upd_seq = {seq_reg[7:0], s_data_byte};
            end else if (pos_reg < LEN_W'(8)) begin
                upd_stamp = {stamp_reg[23:0], s_data_byte};
            end else if (pos_reg < FIXED_HDR) begin
                upd_source = {source_reg[23:0], s_data_byte};
            end
            if (pos_reg >= LEN_W'(2) && pos_reg == ext_hi_pos) begin
                upd_ext = {s_data_byte, ext_words_reg[7:0]};
            end else if (pos_reg >= LEN_W'(2) && pos_reg == ext_lo_pos) begin
                upd_ext = {ext_words_reg[15:8], s_data_byte};
            end
            upd_pos = pos_reg + LEN_W'(1);
        end
    end

    always_comb begin
        pos_next         = pos_reg;
        first_byte_next  = first_byte_reg;
        second_byte_next = second_byte_reg;
        seq_next         = seq_reg;
        stamp_next       = stamp_reg;
        source_next      = source_reg;
        ext_words_next   = ext_words_reg;
        too_long_next    = too_long_reg;
        if (s_xfer) begin
            if (s_last) begin
                pos_next         = '0;
                first_byte_next  = '0;
                second_byte_next = '0;
                seq_next         = '0;
                stamp_next       = '0;
                source_next      = '0;
                ext_words_next   = '0;
                too_long_next    = 1'b0;
            end else begin
                pos_next         = upd_pos;
                first_byte_next  = upd_first;
                second_byte_next = upd_second;
                seq_next         = upd_seq;
                stamp_next       = upd_stamp;
                source_next      = upd_source;
                ext_words_next   = upd_ext;
                too_long_next    = upd_too_long;
            end
        end
    end

    // snapshot of the finished packet
    assign hdr_off_upd = HDR_BASE + {upd_first[3:0], 2'b00};

    always_comb begin
        snap_next       = snap_reg;
        snap_valid_next = snap_valid_reg;
        if (snap_move) begin
            snap_valid_next = 1'b0;
        end
        if (s_xfer && s_last) begin
            snap_valid_next       = 1'b1;
            snap_next.len         = upd_pos;
            snap_next.first_byte  = upd_first;
            snap_next.second_byte = upd_second;
            snap_next.seq         = upd_seq;
            snap_next.stamp       = upd_stamp;
            snap_next.source      = upd_source;
            snap_next.hdr_off     = hdr_off_upd;
            snap_next.ext_off     = OFF_W'(hdr_off_upd) + EXT_HDR + {1'b0, upd_ext, 2'b00};
            snap_next.pad_count   = s_data_byte;
            snap_next.too_long    = upd_too_long;
        end
    end

    // packet checks
    assign len_ext = OFF_W'(snap_reg.len);
    assign off_sel = snap_reg.first_byte[BIT_EXT] ? snap_reg.ext_off
                                                  : OFF_W'(snap_reg.hdr_off);
    assign avail   = len_ext - off_sel;
    assign pad_ext = snap_reg.first_byte[BIT_PAD] ? OFF_W'(snap_reg.pad_count) : '0;
    assign pay_len = avail - pad_ext;

    assign good_base = !snap_reg.too_long && (snap_reg.len >= FIXED_HDR)
                       && (snap_reg.first_byte[7:6] == RTP_VERSION)
                       && (off_sel <= len_ext);
    assign pad_bad   = snap_reg.first_byte[BIT_PAD]
                       && ((snap_reg.pad_count == 8'd0) || (pad_ext > avail));
    assign good      = good_base && !pad_bad;

    always_comb begin
        out_valid_next = out_valid_reg;
        ok_next        = ok_reg;
        marker_next    = marker_reg;
        ptype_next     = ptype_reg;
        oseq_next      = oseq_reg;
        ostamp_next    = ostamp_reg;
        osource_next   = osource_reg;
        pstart_next    = pstart_reg;
        plen_next      = plen_reg;
        if (out_load) begin
            out_valid_next = snap_valid_reg;
            ok_next        = good;
            marker_next    = good & snap_reg.second_byte[BIT_MARKER];
            ptype_next     = good ? snap_reg.second_byte[6:0] : '0;
            oseq_next      = good ? snap_reg.seq : '0;
            ostamp_next    = good ? snap_reg.stamp : '0;
            osource_next   = good ? snap_reg.source : '0;
            pstart_next    = good ? off_sel[OUT_W-1:0] : '0;
            plen_next      = good ? pay_len[OUT_W-1:0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            first_byte_reg  <= '0;
            second_byte_reg <= '0;
            seq_reg         <= '0;
            stamp_reg       <= '0;
            source_reg      <= '0;
            ext_words_reg   <= '0;
            too_long_reg    <= 1'b0;
            snap_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            pos_reg         <= pos_next;
            first_byte_reg  <= first_byte_next;
            second_byte_reg <= second_byte_next;
            seq_reg         <= seq_next;
            stamp_reg       <= stamp_next;
            source_reg      <= source_next;
            ext_words_reg   <= ext_words_next;
            too_long_reg    <= too_long_next;
            snap_valid_reg  <= snap_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        snap_reg    <= snap_next;
        ok_reg      <= ok_next;
        marker_reg  <= marker_next;
        ptype_reg   <= ptype_next;
        oseq_reg    <= oseq_next;
        ostamp_reg  <= ostamp_next;
        osource_reg <= osource_next;
        pstart_reg  <= pstart_next;
        plen_reg    <= plen_next;
    end

    assign m_valid           = out_valid_reg;
    assign m_ok              = ok_reg;
    assign m_marker          = marker_reg;
    assign m_payload_type    = ptype_reg;
    assign m_sequence_number = oseq_reg;
    assign m_time_stamp      = ostamp_reg;
    assign m_source_id       = osource_reg;
    assign m_payload_start   = pstart_reg;
    assign m_payload_length  = plen_reg;

    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= MAX_POS)
        else $error("byte position beyond limit");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> m_payload_start == '0 && m_payload_length == '0
            && m_source_id == '0 && m_time_stamp == '0 && !m_marker)
        else $error("rejected packet carries nonzero fields");

    a_start_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ok |-> m_payload_start >= OUT_W'(12))
        else $error("payload start inside fixed header");

    a_fit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ok |->
            (OFF_W'(m_payload_start) + OFF_W'(m_payload_length)) <= OFF_W'(MAX_LEN))
        else $error("payload runs past packet limit");

    a_snap_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> snap_valid_reg && pos_reg == '0)
        else $error("final byte not captured or state not cleared");

endmodule
